/* design/tlpeq_pkg.sv */
`default_nettype none

package tlpeq_pkg;

  // operation codes
  localparam logic OP_ADD  = 1'b0;
  localparam logic OP_EXEC = 1'b1;

  // priority levels, level 0 is served first
  localparam int NUM_LEVELS = 3;
  localparam logic [1:0] LVL_HIGH = 2'd0;
  localparam logic [1:0] LVL_MED  = 2'd1;
  localparam logic [1:0] LVL_LOW  = 2'd2;

  // field widths
  localparam int ID_W    = 8;
  localparam int PRIO_W  = 2;
  localparam int EVENT_W = 3 * ID_W;
  localparam int ID_SPAN = 1 << ID_W;

  typedef enum logic [1:0] {
    ST_ADDED = 2'd0,
    ST_FULL  = 2'd1,
    ST_EXEC  = 2'd2,
    ST_EMPTY = 2'd3
  } status_t;

endpackage

`default_nettype wire

/* design/tlpeq_ram.sv */
`default_nettype none

module tlpeq_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire                      clk,
  input  wire                      we,
  input  wire  [$clog2(DEPTH)-1:0] waddr,
  input  wire  [WIDTH-1:0]         wdata,
  input  wire                      re,
  input  wire  [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

`default_nettype wire

/* design/three_level_priority_event_queue_unit.sv */
// an accepted input word passes the queue memory read, the device status memory read
// and the output register in turn before its result word appears
// throughput: one word per cycle, adds and executes in any mix, no bubbles while out_ready holds
// reset: synchronous, active low; queues empty, pipeline and output empty
// after reset the device status memory is swept to off, with in_ready low until the sweep is done
`default_nettype none

module three_level_priority_event_queue_unit
  import tlpeq_pkg::*;
#(
  parameter int QUEUE_DEPTH = 16,
  parameter int NUM_DEVICES = 256
) (
  input  wire               clk,
  input  wire               rst_n,
  // input channel
  input  wire               in_valid,
  output logic              in_ready,
  input  wire               in_op,
  input  wire  [ID_W-1:0]   in_device_id,
  input  wire  [ID_W-1:0]   in_sensor_id,
  input  wire  [ID_W-1:0]   in_event_tag,
  input  wire  [PRIO_W-1:0] in_priority_req,
  // result channel
  output logic              out_valid,
  input  wire               out_ready,
  output logic [1:0]        out_status_code,
  output logic [1:0]        out_served_level,
  output logic [ID_W-1:0]   out_device_id,
  output logic [ID_W-1:0]   out_sensor_id,
  output logic [ID_W-1:0]   out_event_tag,
  output logic              out_device_now_on
);

  localparam int PTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W      = $clog2(QUEUE_DEPTH + 1);
  localparam int QRAM_DEPTH = NUM_LEVELS * QUEUE_DEPTH;
  localparam int QADDR_W    = $clog2(QRAM_DEPTH);
  localparam int DEV_W      = $clog2(NUM_DEVICES);

  localparam logic [PTR_W-1:0]   PTR_LAST = PTR_W'(QUEUE_DEPTH - 1);
  localparam logic [CNT_W-1:0]   CNT_FULL = CNT_W'(QUEUE_DEPTH);
  localparam logic [DEV_W-1:0]   DEV_LAST = DEV_W'(NUM_DEVICES - 1);
  localparam logic [QADDR_W-1:0] LVL_SPAN = QADDR_W'(QUEUE_DEPTH);

  // ------------------------------------------------------------------
  // queue control state, one set of pointers and a count per level
  // ------------------------------------------------------------------
  logic [PTR_W-1:0] head_r  [NUM_LEVELS];
  logic [PTR_W-1:0] tail_r  [NUM_LEVELS];
  logic [CNT_W-1:0] count_r [NUM_LEVELS];
  logic [PTR_W-1:0] head_nxt  [NUM_LEVELS];
  logic [PTR_W-1:0] tail_nxt  [NUM_LEVELS];
  logic [CNT_W-1:0] count_nxt [NUM_LEVELS];

  // device status clearing sweep after reset
  logic             clearing_r;
  logic [DEV_W-1:0] clr_idx_r;

  // pipeline handshake
  logic valid1_r, valid2_r, out_valid_r;
  logic out_free, adv2, s2_free, adv1, s1_free, in_fire;

  assign out_free = !out_valid_r || out_ready;
  assign adv2     = valid2_r && out_free;
  assign s2_free  = !valid2_r || adv2;
  assign adv1     = valid1_r && s2_free;
  assign s1_free  = !valid1_r || adv1;
  assign in_ready = s1_free && !clearing_r;
  assign in_fire  = in_valid && in_ready;

  // ------------------------------------------------------------------
  // stage 0: level pick, full / empty checks, queue memory access
  // ------------------------------------------------------------------
  logic [1:0]         add_lvl, pop_lvl;
  logic               any_ev, add_full;
  logic               q_we, q_re;
  logic [QADDR_W-1:0] q_waddr, q_raddr;
  logic [EVENT_W-1:0] q_rdata;
  status_t            st0;

  // codes other than high or medium land in the low queue
  always_comb begin
    case (in_priority_req)
      LVL_HIGH: add_lvl = LVL_HIGH;
      LVL_MED:  add_lvl = LVL_MED;
      default:  add_lvl = LVL_LOW;
    endcase
  end

  // strict priority: lowest non-empty level wins
  always_comb begin
    if (count_r[LVL_HIGH] != '0) begin
      pop_lvl = LVL_HIGH;
    end else if (count_r[LVL_MED] != '0) begin
      pop_lvl = LVL_MED;
    end else begin
      pop_lvl = LVL_LOW;
    end
  end

  assign any_ev   = (count_r[LVL_HIGH] != '0) || (count_r[LVL_MED] != '0) ||
                    (count_r[LVL_LOW] != '0);
  assign add_full = (count_r[add_lvl] == CNT_FULL);

  assign q_we    = in_fire && (in_op == OP_ADD) && !add_full;
  assign q_re    = in_fire && (in_op == OP_EXEC) && any_ev;
  // each level owns a contiguous block of QUEUE_DEPTH slots
  assign q_waddr = LVL_SPAN * QADDR_W'(add_lvl) + QADDR_W'(tail_r[add_lvl]);
  assign q_raddr = LVL_SPAN * QADDR_W'(pop_lvl) + QADDR_W'(head_r[pop_lvl]);

  always_comb begin
    if (in_op == OP_ADD) begin
      st0 = add_full ? ST_FULL : ST_ADDED;
    end else begin
      st0 = any_ev ? ST_EXEC : ST_EMPTY;
    end
  end

  always_comb begin
    head_nxt  = head_r;
    tail_nxt  = tail_r;
    count_nxt = count_r;
    if (q_we) begin
      tail_nxt[add_lvl]  = (tail_r[add_lvl] == PTR_LAST) ? '0 : tail_r[add_lvl] + 1'b1;
      count_nxt[add_lvl] = count_r[add_lvl] + 1'b1;
    end
    if (q_re) begin
      head_nxt[pop_lvl]  = (head_r[pop_lvl] == PTR_LAST) ? '0 : head_r[pop_lvl] + 1'b1;
      count_nxt[pop_lvl] = count_r[pop_lvl] - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_LEVELS; i++) begin
        head_r[i]  <= '0;
        tail_r[i]  <= '0;
        count_r[i] <= '0;
      end
    end else begin
      head_r  <= head_nxt;
      tail_r  <= tail_nxt;
      count_r <= count_nxt;
    end
  end

  // event word packed as {device, sensor, tag}
  tlpeq_ram #(
    .WIDTH (EVENT_W),
    .DEPTH (QRAM_DEPTH)
  ) u_queue_ram (
    .clk   (clk),
    .we    (q_we),
    .waddr (q_waddr),
    .wdata ({in_device_id, in_sensor_id, in_event_tag}),
    .re    (q_re),
    .raddr (q_raddr),
    .rdata (q_rdata)
  );

  // ------------------------------------------------------------------
  // stage 1: event word from the queue memory, device status read
  // ------------------------------------------------------------------
  status_t    st1_r;
  logic [1:0] lvl1_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid1_r <= 1'b0;
    end else if (in_fire) begin
      valid1_r <= 1'b1;
    end else if (adv1) begin
      valid1_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      st1_r  <= st0;
      lvl1_r <= pop_lvl;
    end
  end

  // device id folded onto the status store, worked out at elaboration
  logic [DEV_W-1:0] dev_map [ID_SPAN];
  for (genvar g = 0; g < ID_SPAN; g++) begin : g_dev_map
    assign dev_map[g] = DEV_W'(g % NUM_DEVICES);
  end

  logic [DEV_W-1:0] dev_idx1;
  assign dev_idx1 = dev_map[q_rdata[EVENT_W-1 -: ID_W]];

  // ------------------------------------------------------------------
  // stage 2: toggle, write back, forward to a follower on the same device
  // ------------------------------------------------------------------
  status_t          st2_r;
  logic [1:0]       lvl2_r;
  logic [ID_W-1:0]  dev2_r, sen2_r, tag2_r;
  logic [DEV_W-1:0] idx2_r;
  logic             fwd_hit_r, fwd_val_r, fwd_hit_nxt;
  logic             d_rdata, old_bit, new_bit, s2_exec;
  logic             d_we, d_wdata;
  logic [DEV_W-1:0] d_waddr;

  assign s2_exec = (st2_r == ST_EXEC);
  // the memory returns old data when the item ahead writes the same entry
  assign old_bit = fwd_hit_r ? fwd_val_r : d_rdata;
  assign new_bit = ~old_bit;

  assign fwd_hit_nxt = adv2 && s2_exec && (st1_r == ST_EXEC) && (idx2_r == dev_idx1);

  // sweep owns the write port until done; no item is in flight then
  assign d_we    = clearing_r || (adv2 && s2_exec);
  assign d_waddr = clearing_r ? clr_idx_r : idx2_r;
  assign d_wdata = clearing_r ? 1'b0 : new_bit;

  tlpeq_ram #(
    .WIDTH (1),
    .DEPTH (NUM_DEVICES)
  ) u_device_ram (
    .clk   (clk),
    .we    (d_we),
    .waddr (d_waddr),
    .wdata (d_wdata),
    .re    (adv1),
    .raddr (dev_idx1),
    .rdata (d_rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid2_r  <= 1'b0;
      fwd_hit_r <= 1'b0;
    end else if (adv1) begin
      valid2_r  <= 1'b1;
      fwd_hit_r <= fwd_hit_nxt;
    end else if (adv2) begin
      valid2_r  <= 1'b0;
      fwd_hit_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv1) begin
      st2_r     <= st1_r;
      lvl2_r    <= lvl1_r;
      dev2_r    <= q_rdata[EVENT_W-1 -: ID_W];
      sen2_r    <= q_rdata[2*ID_W-1 -: ID_W];
      tag2_r    <= q_rdata[ID_W-1:0];
      idx2_r    <= dev_idx1;
      fwd_val_r <= new_bit;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clearing_r <= 1'b1;
      clr_idx_r  <= '0;
    end else if (clearing_r) begin
      clr_idx_r <= clr_idx_r + 1'b1;
      if (clr_idx_r == DEV_LAST) begin
        clearing_r <= 1'b0;
      end
    end
  end

  // ------------------------------------------------------------------
  // output register, event fields read as zero unless an event ran
  // ------------------------------------------------------------------
  status_t         out_status_r;
  logic [1:0]      out_level_r;
  logic [ID_W-1:0] out_dev_r, out_sen_r, out_tag_r;
  logic            out_on_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv2) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv2) begin
      out_status_r <= st2_r;
      out_level_r  <= s2_exec ? lvl2_r : '0;
      out_dev_r    <= s2_exec ? dev2_r : '0;
      out_sen_r    <= s2_exec ? sen2_r : '0;
      out_tag_r    <= s2_exec ? tag2_r : '0;
      out_on_r     <= s2_exec && new_bit;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_status_code   = out_status_r;
  assign out_served_level  = out_level_r;
  assign out_device_id     = out_dev_r;
  assign out_sensor_id     = out_sen_r;
  assign out_event_tag     = out_tag_r;
  assign out_device_now_on = out_on_r;

  // ------------------------------------------------------------------
  // checks
  // ------------------------------------------------------------------
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (count_r[LVL_HIGH] <= CNT_FULL) && (count_r[LVL_MED] <= CNT_FULL) &&
    (count_r[LVL_LOW] <= CNT_FULL))
    else $error("queue count above depth");

  a_sweep_blocks: assert property (@(posedge clk) disable iff (!rst_n)
    clearing_r |-> !in_ready)
    else $error("input taken during status sweep");

  a_empty_exec: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && (in_op == OP_EXEC) && !any_ev) |=> (valid1_r && (st1_r == ST_EMPTY)))
    else $error("execute on empty queues not flagged");

  a_fwd_exec: assert property (@(posedge clk) disable iff (!rst_n)
    fwd_hit_r |-> (valid2_r && s2_exec))
    else $error("status forward without an execute in flight");

  a_add_fields_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && ((out_status_r == ST_ADDED) || (out_status_r == ST_FULL)))
      |-> ((out_dev_r == '0) && !out_on_r && (out_level_r == '0)))
    else $error("add result carries event fields");

endmodule

`default_nettype wire
